### hdl/emsd_pkg.sv
`timescale 1ns / 1ps

package emsd_pkg;

  localparam int unsigned EchoW     = 15;
  localparam int unsigned SideW     = 12;
  localparam int unsigned FrontW    = 14;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned ThreshW   = 12;
  localparam int unsigned CountW    = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Division by 29 is done as a multiplication by a scaled reciprocal.
  // The reciprocal is rounded up, and the result is exact for every
  // dividend below 2^18.
  localparam int unsigned DivInW    = EchoW + 3;
  localparam int unsigned RecipW    = 19;
  localparam int unsigned RecipSh   = 23;
  localparam int unsigned ProdW     = DivInW + RecipW;
  localparam logic [RecipW-1:0] RecipMul = RecipW'(289263);

  localparam logic [FrontW-1:0] FrontTimeout = FrontW'(15984);
  localparam logic [FrontW-1:0] FrontReset   = FrontW'(480);
  localparam logic [CountW-1:0] CountMax     = '1;

  localparam logic [IntervalW-1:0] IntervalReset = IntervalW'(500);
  localparam logic [ThreshW-1:0]   ThreshReset   = ThreshW'(48);
  localparam logic [CountW-1:0]    LimitReset    = CountW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHECK_INTERVAL = 2'd0,
    CFG_MOVE_THRESHOLD = 2'd1,
    CFG_STALL_LIMIT    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [IntervalW-1:0] check_interval_ms;
    logic [ThreshW-1:0]   move_threshold;
    logic [CountW-1:0]    stall_limit;
  } cfg_t;

  typedef struct packed {
    logic [FrontW-1:0] front;
    logic [SideW-1:0]  left_dist;
    logic [SideW-1:0]  right_dist;
    logic [TimeW-1:0]  now_ms;
    logic              in_motion;
  } item_t;

  typedef struct packed {
    logic [FrontW-1:0] front_dist;
    logic              check_done;
    logic              reverse_request;
  } result_t;

endpackage

### hdl/emsd_front_conv.sv
`timescale 1ns / 1ps

module emsd_front_conv import emsd_pkg::*; (
  input  logic [EchoW-1:0]  echo_us_i,
  output logic [FrontW-1:0] front_o
);

  logic [DivInW-1:0] scaled;
  logic [ProdW-1:0]  prod;

  assign scaled = {echo_us_i, 3'b000};
  assign prod   = ProdW'(scaled) * ProdW'(RecipMul);

  always_comb begin
    if (echo_us_i == '0) begin
      front_o = FrontTimeout;
    end else begin
      front_o = prod[RecipSh +: FrontW];
    end
  end

endmodule

### hdl/emsd_stall_core.sv
`timescale 1ns / 1ps

module emsd_stall_core import emsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [FrontW-1:0] hist0_q, hist1_q;
  logic [FrontW-1:0] saved_front_q;
  logic [SideW-1:0]  saved_left_q, saved_right_q;
  logic [TimeW-1:0]  last_check_q;
  logic [CountW-1:0] count_q, count_d;

  logic [FrontW-1:0] lo01, hi01, mid_hi, med;
  logic [TimeW-1:0]  elapsed;
  logic              check;
  logic [FrontW-1:0] diff_front;
  logic [SideW-1:0]  diff_left, diff_right;
  logic              still;
  logic [CountW-1:0] count_step;
  logic              reverse;

  // Median of the new value and the two previous ones.
  always_comb begin
    lo01   = (item_i.front < hist0_q) ? item_i.front : hist0_q;
    hi01   = (item_i.front < hist0_q) ? hist0_q : item_i.front;
    mid_hi = (hi01 < hist1_q) ? hi01 : hist1_q;
    med    = (lo01 > mid_hi) ? lo01 : mid_hi;
  end

  assign elapsed = item_i.now_ms - last_check_q;
  assign check   = elapsed > TimeW'(cfg_i.check_interval_ms);

  always_comb begin
    diff_front = (med > saved_front_q) ? med - saved_front_q : saved_front_q - med;
    diff_left  = (item_i.left_dist > saved_left_q) ? item_i.left_dist - saved_left_q
                                                   : saved_left_q - item_i.left_dist;
    diff_right = (item_i.right_dist > saved_right_q) ? item_i.right_dist - saved_right_q
                                                     : saved_right_q - item_i.right_dist;
    still = (diff_front < FrontW'(cfg_i.move_threshold)) &&
            (diff_left < cfg_i.move_threshold) &&
            (diff_right < cfg_i.move_threshold);
  end

  always_comb begin
    count_step = '0;
    reverse    = 1'b0;
    count_d    = count_q;
    if (check && item_i.in_motion) begin
      if (still) begin
        count_step = (count_q == CountMax) ? count_q : count_q + 1'b1;
      end
      if (count_step >= cfg_i.stall_limit) begin
        reverse = 1'b1;
        count_d = '0;
      end else begin
        count_d = count_step;
      end
    end
  end

  assign result_o.front_dist      = med;
  assign result_o.check_done      = check;
  assign result_o.reverse_request = reverse;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist0_q       <= FrontReset;
      hist1_q       <= FrontReset;
      saved_front_q <= '0;
      saved_left_q  <= '0;
      saved_right_q <= '0;
      last_check_q  <= '0;
      count_q       <= '0;
    end else if (advance_i) begin
      hist0_q <= item_i.front;
      hist1_q <= hist0_q;
      count_q <= count_d;
      if (check) begin
        saved_front_q <= med;
        saved_left_q  <= item_i.left_dist;
        saved_right_q <= item_i.right_dist;
        last_check_q  <= item_i.now_ms;
      end
    end
  end

endmodule

### hdl/echo_median_stall_detect_unit.sv
`timescale 1ns / 1ps
// Channel  | Handshake                   | Payload
// in       | in_valid_i / in_ready_o     | echo_us_i left_dist_i right_dist_i now_ms_i in_motion_i
// out      | out_valid_o / out_ready_i   | front_dist_o check_done_o reverse_request_o
// cfg      | cfg_we_i                    | cfg_idx_i cfg_wdata_i
//
// A beat is taken every cycle unless the output stalls; it passes the input and result registers.
// The echo conversion sits before the input register, the median and stall check
// between the input register and the result register, where the state is updated.
// Reset clears the filter history to 30 cm and all saved values and counts to zero.
// A stalled result holds one more beat in the input register, then ready drops.

module echo_median_stall_detect_unit import emsd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [EchoW-1:0]     echo_us_i,
  input  logic [SideW-1:0]     left_dist_i,
  input  logic [SideW-1:0]     right_dist_i,
  input  logic [TimeW-1:0]     now_ms_i,
  input  logic                 in_motion_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FrontW-1:0]    front_dist_o,
  output logic                 check_done_o,
  output logic                 reverse_request_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  cfg_t              cfg_q;
  item_t             item_q;
  logic              item_valid_q;
  result_t           res_q;
  logic              res_valid_q;
  logic [FrontW-1:0] front_in;
  result_t           res_d;
  logic              advance;
  logic              accept;

  emsd_front_conv u_conv (
    .echo_us_i (echo_us_i),
    .front_o   (front_in)
  );

  emsd_stall_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cfg_i     (cfg_q),
    .item_i    (item_q),
    .result_o  (res_d)
  );

  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_interval_ms <= IntervalReset;
      cfg_q.move_threshold    <= ThreshReset;
      cfg_q.stall_limit       <= LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHECK_INTERVAL: cfg_q.check_interval_ms <= cfg_wdata_i[IntervalW-1:0];
        CFG_MOVE_THRESHOLD: cfg_q.move_threshold    <= cfg_wdata_i[ThreshW-1:0];
        CFG_STALL_LIMIT:    cfg_q.stall_limit       <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.front      <= front_in;
      item_q.left_dist  <= left_dist_i;
      item_q.right_dist <= right_dist_i;
      item_q.now_ms     <= now_ms_i;
      item_q.in_motion  <= in_motion_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = res_valid_q;
  assign front_dist_o      = res_q.front_dist;
  assign check_done_o      = res_q.check_done;
  assign reverse_request_o = res_q.reverse_request;

endmodule

### hdl/emsd_checker.sv
`timescale 1ns / 1ps

module emsd_checker import emsd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [FrontW-1:0] front_dist_o,
  input logic              check_done_o,
  input logic              reverse_request_o
);

  // The input side only stalls while a finished result is waiting.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // An accepted beat is followed by a result on the output once it has passed the input and result registers.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##2 out_valid_o)
    else $error("no result after an accepted beat");

  // A reverse request only comes out of a stall check.
  a_reverse_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reverse_request_o) |-> check_done_o)
    else $error("reverse request without a check");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(front_dist_o) &&
      $stable(check_done_o) && $stable(reverse_request_o)))
    else $error("stalled result changed");

endmodule

bind echo_median_stall_detect_unit emsd_checker u_emsd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .front_dist_o      (front_dist_o),
  .check_done_o      (check_done_o),
  .reverse_request_o (reverse_request_o)
);
